@@ design/mrrs_pkg.sv @@
package mrrs_pkg;

    localparam int SPEED_W    = 16;
    localparam int INC_W      = 16;
    localparam int TICK_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // input item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BUSY  = 2'd1,
        ST_RANGE = 2'd2,
        ST_SAME  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DOWN_ON  = 3'd1,
        PH_DOWN_OFF = 3'd2,
        PH_DWELL    = 3'd3,
        PH_UP_ON    = 3'd4,
        PH_UP_OFF   = 3'd5
    } phase_t;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_NORMAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_REVERSE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 3'd4;

    localparam logic [CFG_DATA_W-1:0] RST_STEP_NORMAL  = 16'd200;
    localparam logic [CFG_DATA_W-1:0] RST_STEP_REVERSE = 16'd500;
    localparam logic [CFG_DATA_W-1:0] RST_HALF_STEP    = 16'd25;
    localparam logic [CFG_DATA_W-1:0] RST_DWELL        = 16'd200;
    localparam logic [CFG_DATA_W-1:0] RST_MAX_SPEED    = 16'd65000;

    typedef struct packed {
        logic [INC_W-1:0]   step_normal;
        logic [INC_W-1:0]   step_reverse_brake;
        logic [TICK_W-1:0]  half_step_ticks;
        logic [TICK_W-1:0]  dwell_ticks;
        logic [SPEED_W-1:0] max_speed;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         direction_code;
        logic               speed_valid;
        logic [SPEED_W-1:0] speed;
    } item_t;

    typedef struct packed {
        logic [SPEED_W-1:0] pwm_level;
        logic               drive_forward;
        logic               drive_reverse;
        logic               led;
        logic               busy_res;
        status_t            status;
    } res_t;

endpackage

@@ design/mrrs_in_if.sv @@
interface mrrs_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [1:0]  direction_code;
    logic        speed_valid;
    logic [15:0] speed;

    modport source (output valid, kind, direction_code, speed_valid, speed, input ready);
    modport sink (input valid, kind, direction_code, speed_valid, speed, output ready);
endinterface

@@ design/mrrs_out_if.sv @@
interface mrrs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pwm_level;
    logic        drive_forward;
    logic        drive_reverse;
    logic        led;
    logic        busy_res;
    logic [1:0]  status;

    modport source (
        output valid, pwm_level, drive_forward, drive_reverse, led, busy_res, status,
        input ready
    );
    modport sink (
        input valid, pwm_level, drive_forward, drive_reverse, led, busy_res, status,
        output ready
    );
endinterface

@@ design/mrrs_cfg_if.sv @@
interface mrrs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/motor_reversal_ramp_sequencer.sv @@
// Soft-start H-bridge sequencer. Each beat on cmd is either a one-millisecond
// tick (kind 0) or a command (kind 1) asking for a direction change, a new
// speed, or both; every beat yields exactly one result beat on res showing
// the PWM level, bridge pins, LED and busy flag after that beat, plus a
// status (ok, refused busy, speed out of range, direction unchanged). The
// block takes one beat per clock while cmd.ready is high. The whole update
// is a single pass of compare/add logic from the state registers into the
// result register, shown on res after earlier results. A two-entry result
// buffer keeps cmd ready while one result waits to be taken; cmd.ready
// drops only when two results are unread. Commands that arrive while a
// ramp or dwell is running are refused, not queued. Registers on cfg
// (always ready) should be written only while the block is idle.
module motor_reversal_ramp_sequencer #(
    parameter int LEVEL_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    mrrs_in_if.sink     cmd,
    mrrs_out_if.source  res,
    mrrs_cfg_if.sink    cfg
);

    mrrs_pkg::cfg_t  regs;
    mrrs_pkg::item_t item;
    mrrs_pkg::res_t  result;
    logic            accept;
    logic            buf_ready;

    // beat handshake on the command side
    assign cmd.ready = buf_ready;
    assign accept    = cmd.valid & buf_ready;

    assign item.kind           = cmd.kind;
    assign item.direction_code = cmd.direction_code;
    assign item.speed_valid    = cmd.speed_valid;
    assign item.speed          = cmd.speed;

    // step sizes, LED half period, dwell and speed limit
    mrrs_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // ramp/dwell phase machine; result is the post-beat view
    mrrs_core #(
        .LEVEL_WIDTH (LEVEL_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (regs),
        .result (result)
    );

    // result register plus skid entry
    mrrs_skid u_skid (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .din   (result),
        .ready (buf_ready),
        .res   (res)
    );

endmodule

@@ design/mrrs_cfg_regs.sv @@
module mrrs_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    mrrs_cfg_if.sink      cfg,
    output mrrs_pkg::cfg_t regs
);

    mrrs_pkg::cfg_t regs_reg;
    mrrs_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                mrrs_pkg::REG_STEP_NORMAL:  regs_next.step_normal        = cfg.data;
                mrrs_pkg::REG_STEP_REVERSE: regs_next.step_reverse_brake = cfg.data;
                mrrs_pkg::REG_HALF_STEP:    regs_next.half_step_ticks    = cfg.data;
                mrrs_pkg::REG_DWELL:        regs_next.dwell_ticks        = cfg.data;
                mrrs_pkg::REG_MAX_SPEED:    regs_next.max_speed          = cfg.data;
                default:                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.step_normal        <= mrrs_pkg::RST_STEP_NORMAL;
            regs_reg.step_reverse_brake <= mrrs_pkg::RST_STEP_REVERSE;
            regs_reg.half_step_ticks    <= mrrs_pkg::RST_HALF_STEP;
            regs_reg.dwell_ticks        <= mrrs_pkg::RST_DWELL;
            regs_reg.max_speed          <= mrrs_pkg::RST_MAX_SPEED;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

@@ design/mrrs_core.sv @@
module mrrs_core #(
    parameter int LEVEL_WIDTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  mrrs_pkg::item_t item,
    input  mrrs_pkg::cfg_t  cfg,
    output mrrs_pkg::res_t  result
);

    localparam int CW = mrrs_pkg::INC_W;
    localparam logic [mrrs_pkg::SPEED_W-1:0] LEVEL_MAX =
        mrrs_pkg::SPEED_W'((32'd1 << LEVEL_WIDTH) - 32'd1);

    typedef struct packed {
        logic [LEVEL_WIDTH-1:0]        level;
        logic [LEVEL_WIDTH-1:0]        saved_level;
        logic [LEVEL_WIDTH-1:0]        ramp_target;
        logic [LEVEL_WIDTH-1:0]        pending_speed;
        logic [mrrs_pkg::INC_W-1:0]    ramp_increment;
        logic [mrrs_pkg::TICK_W-1:0]   tick_count;
        mrrs_pkg::phase_t              phase;
        logic                          reversed;
        logic                          pending_flag;
        logic                          led;
    } core_st_t;

    core_st_t st_reg;
    core_st_t st_next;
    core_st_t pre;
    core_st_t post;
    logic     call_step;
    logic [mrrs_pkg::TICK_W-1:0] tick_inc;
    logic [mrrs_pkg::TICK_W-1:0] half;
    logic [mrrs_pkg::TICK_W-1:0] dwell;
    mrrs_pkg::status_t status;
    logic     change;

    function automatic logic [15:0] at_least_one(logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // one clamped move of cur toward tgt
    function automatic logic [LEVEL_WIDTH-1:0] step_toward(
        logic [LEVEL_WIDTH-1:0] cur,
        logic [LEVEL_WIDTH-1:0] tgt,
        logic [CW-1:0]          inc
    );
        logic [LEVEL_WIDTH-1:0] diff;
        logic [LEVEL_WIDTH-1:0] r;
        if (tgt > cur)
        begin
            diff = tgt - cur;
            r = (CW'(diff) >= inc) ? cur + LEVEL_WIDTH'(inc) : tgt;
        end
        else
        begin
            diff = cur - tgt;
            r = (CW'(diff) >= inc) ? cur - LEVEL_WIDTH'(inc) : tgt;
        end
        return r;
    endfunction

    // Take the next ramp step or close out the phase. A pending speed can
    // retarget once, so two passes cover every case.
    function automatic core_st_t next_step(core_st_t s, logic [CW-1:0] step_normal);
        logic done;
        done = 1'b0;
        for (int pass = 0; pass < 2; pass++)
        begin
            if (!done)
            begin
                if (s.level != s.ramp_target)
                begin
                    s.level      = step_toward(s.level, s.ramp_target,
                                               at_least_one(s.ramp_increment));
                    s.led        = 1'b1;
                    s.tick_count = '0;
                    s.phase      = (s.phase == mrrs_pkg::PH_DOWN_OFF) ?
                                   mrrs_pkg::PH_DOWN_ON : mrrs_pkg::PH_UP_ON;
                    done         = 1'b1;
                end
                else if (s.phase == mrrs_pkg::PH_DOWN_OFF)
                begin
                    // at zero: swap bridge pins, start dwell
                    s.reversed   = ~s.reversed;
                    s.led        = 1'b1;
                    s.tick_count = '0;
                    s.phase      = mrrs_pkg::PH_DWELL;
                    done         = 1'b1;
                end
                else if (s.pending_flag)
                begin
                    s.pending_flag   = 1'b0;
                    s.ramp_target    = s.pending_speed;
                    s.saved_level    = s.pending_speed;
                    s.ramp_increment = step_normal;
                end
                else
                begin
                    s.phase = mrrs_pkg::PH_IDLE;
                    done    = 1'b1;
                end
            end
        end
        return s;
    endfunction

    always_comb
    begin
        pre       = st_reg;
        call_step = 1'b0;
        change    = 1'b0;
        status    = mrrs_pkg::ST_OK;
        tick_inc  = st_reg.tick_count + 16'd1;
        half      = at_least_one(cfg.half_step_ticks);
        dwell     = at_least_one(cfg.dwell_ticks);

        if (item.kind == mrrs_pkg::KIND_TICK)
        begin
            unique case (st_reg.phase) inside
                mrrs_pkg::PH_DOWN_ON, mrrs_pkg::PH_UP_ON:
                begin
                    pre.tick_count = tick_inc;
                    if (tick_inc >= half)
                    begin
                        pre.led        = 1'b0;
                        pre.tick_count = '0;
                        pre.phase      = (st_reg.phase == mrrs_pkg::PH_DOWN_ON) ?
                                         mrrs_pkg::PH_DOWN_OFF : mrrs_pkg::PH_UP_OFF;
                    end
                end
                mrrs_pkg::PH_DOWN_OFF, mrrs_pkg::PH_UP_OFF:
                begin
                    pre.tick_count = tick_inc;
                    call_step      = (tick_inc >= half);
                end
                mrrs_pkg::PH_DWELL:
                begin
                    pre.tick_count = tick_inc;
                    if (tick_inc >= dwell)
                    begin
                        pre.ramp_target    = st_reg.saved_level;
                        pre.ramp_increment = cfg.step_normal;
                        pre.phase          = mrrs_pkg::PH_UP_OFF;
                        call_step          = 1'b1;
                    end
                end
                default: pre.phase = mrrs_pkg::PH_IDLE;
            endcase
        end
        else if (st_reg.phase != mrrs_pkg::PH_IDLE)
        begin
            status = mrrs_pkg::ST_BUSY;
        end
        else
        begin
            unique case (item.direction_code)
                mrrs_pkg::DIR_FWD:
                begin
                    if (st_reg.reversed) change = 1'b1;
                    else                 status = mrrs_pkg::ST_SAME;
                end
                mrrs_pkg::DIR_REV:
                begin
                    if (!st_reg.reversed) change = 1'b1;
                    else                  status = mrrs_pkg::ST_SAME;
                end
                default: change = 1'b0;
            endcase

            if (item.speed_valid)
            begin
                if ((item.speed > cfg.max_speed) || (item.speed > LEVEL_MAX))
                begin
                    status = mrrs_pkg::ST_RANGE;
                end
                else
                begin
                    pre.pending_speed = item.speed[LEVEL_WIDTH-1:0];
                    pre.pending_flag  = 1'b1;
                end
            end

            if (change)
            begin
                pre.ramp_target    = '0;
                pre.ramp_increment =
                    (item.direction_code == mrrs_pkg::DIR_REV) ?
                    cfg.step_reverse_brake : cfg.step_normal;
                pre.phase          = mrrs_pkg::PH_DOWN_OFF;
                call_step          = 1'b1;
            end
            else if (pre.pending_flag)
            begin
                pre.ramp_target = st_reg.level;
                pre.phase       = mrrs_pkg::PH_UP_OFF;
                call_step       = 1'b1;
            end
        end

        post    = call_step ? next_step(pre, cfg.step_normal) : pre;
        st_next = accept ? post : st_reg;

        result.pwm_level     = mrrs_pkg::SPEED_W'(post.level);
        result.drive_forward = ~post.reversed;
        result.drive_reverse = post.reversed;
        result.led           = post.led;
        result.busy_res      = (post.phase != mrrs_pkg::PH_IDLE);
        result.status        = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

@@ design/mrrs_skid.sv @@
module mrrs_skid (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  mrrs_pkg::res_t din,
    output logic           ready,
    mrrs_out_if.source     res
);

    mrrs_pkg::res_t main_reg;
    mrrs_pkg::res_t main_next;
    mrrs_pkg::res_t skid_reg;
    mrrs_pkg::res_t skid_next;
    logic           main_valid_reg;
    logic           main_valid_next;
    logic           skid_valid_reg;
    logic           skid_valid_next;
    logic           out_fire;

    assign ready    = ~skid_valid_reg;
    assign out_fire = main_valid_reg & res.ready;

    assign res.valid         = main_valid_reg;
    assign res.pwm_level     = main_reg.pwm_level;
    assign res.drive_forward = main_reg.drive_forward;
    assign res.drive_reverse = main_reg.drive_reverse;
    assign res.led           = main_reg.led;
    assign res.busy_res      = main_reg.busy_res;
    assign res.status        = main_reg.status;

    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;

        if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end

        if (load)
        begin
            if (!main_valid_next)
            begin
                main_next       = din;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = din;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

@@ verif/mrrs_ramp_checker.sv @@
`timescale 1ns / 100ps

module mrrs_ramp_checker #(
    parameter int LEVEL_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    mrrs_in_if   cmd,
    mrrs_out_if  res,
    mrrs_cfg_if  cfg,
    output int   drive_mismatches,
    output int   readings_owed,
    output logic sequence_running
);
    import mrrs_pkg::*;

    localparam int LEVEL_MAX = (1 << LEVEL_WIDTH) - 1;

    // mirror of the sequencer state
    cfg_t               regs;
    logic [SPEED_W-1:0] duty, resume_duty, goal, queued_speed;
    logic [INC_W-1:0]   step_size;
    logic [TICK_W-1:0]  tick_cnt;
    logic               swapped, speed_queued, lamp;
    phase_t             stage;

    res_t expected_drive[$];
    int   misses = 0;

    assign drive_mismatches = misses;

    function automatic logic [15:0] floor_one(input logic [15:0] v);
        return (v == '0) ? 16'd1 : v;
    endfunction

    // take the next ramp step, or move on once the goal is reached
    function automatic void advance_ramp();
        logic [INC_W-1:0] inc;
        bit               settled;
        settled = 1'b0;
        while (!settled)
        begin
            inc = floor_one(step_size);
            if (duty != goal)
            begin
                if (goal > duty)
                    duty = (goal - duty >= inc) ? duty + inc : goal;
                else
                    duty = (duty - goal >= inc) ? duty - inc : goal;
                lamp     = 1'b1;
                tick_cnt = '0;
                stage    = (stage == PH_DOWN_OFF) ? PH_DOWN_ON : PH_UP_ON;
                settled  = 1'b1;
            end
            else if (stage == PH_DOWN_OFF)
            begin
                swapped  = !swapped;
                lamp     = 1'b1;
                tick_cnt = '0;
                stage    = PH_DWELL;
                settled  = 1'b1;
            end
            else if (speed_queued)
            begin
                speed_queued = 1'b0;
                goal         = queued_speed;
                resume_duty  = queued_speed;
                step_size    = regs.step_normal;
            end
            else
            begin
                stage   = PH_IDLE;
                settled = 1'b1;
            end
        end
    endfunction

    function automatic void apply_tick();
        logic [TICK_W-1:0] half;
        half = floor_one(regs.half_step_ticks);
        case (stage)
            PH_DOWN_ON, PH_UP_ON:
            begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= half)
                begin
                    lamp     = 1'b0;
                    tick_cnt = '0;
                    stage    = (stage == PH_DOWN_ON) ? PH_DOWN_OFF : PH_UP_OFF;
                end
            end
            PH_DOWN_OFF, PH_UP_OFF:
            begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= half)
                    advance_ramp();
            end
            PH_DWELL:
            begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt >= floor_one(regs.dwell_ticks))
                begin
                    goal      = resume_duty;
                    step_size = regs.step_normal;
                    stage     = PH_UP_OFF;
                    advance_ramp();
                end
            end
            default: stage = PH_IDLE;
        endcase
    endfunction

    function automatic status_t apply_command(input logic [1:0] dir, input logic spd_valid,
                                              input logic [SPEED_W-1:0] spd);
        status_t st;
        bit      turn;
        st   = ST_OK;
        turn = 1'b0;
        if (stage != PH_IDLE)
            return ST_BUSY;
        if (dir == DIR_FWD)
        begin
            if (swapped)
                turn = 1'b1;
            else
                st = ST_SAME;
        end
        else if (dir == DIR_REV)
        begin
            if (!swapped)
                turn = 1'b1;
            else
                st = ST_SAME;
        end
        if (spd_valid)
        begin
            if (spd > regs.max_speed || int'(spd) > LEVEL_MAX)
                st = ST_RANGE;
            else
            begin
                queued_speed = spd;
                speed_queued = 1'b1;
            end
        end
        if (turn)
        begin
            goal      = '0;
            step_size = (dir == DIR_REV) ? regs.step_reverse_brake : regs.step_normal;
            stage     = PH_DOWN_OFF;
            advance_ramp();
        end
        else if (speed_queued)
        begin
            goal  = duty;
            stage = PH_UP_OFF;
            advance_ramp();
        end
        return st;
    endfunction

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want)
        begin
            misses++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t    want;
        status_t st;
        if (!rst_n)
        begin
            regs.step_normal        = RST_STEP_NORMAL;
            regs.step_reverse_brake = RST_STEP_REVERSE;
            regs.half_step_ticks    = RST_HALF_STEP;
            regs.dwell_ticks        = RST_DWELL;
            regs.max_speed          = RST_MAX_SPEED;
            duty         = '0;
            resume_duty  = '0;
            goal         = '0;
            queued_speed = '0;
            step_size    = '0;
            tick_cnt     = '0;
            swapped      = 1'b0;
            speed_queued = 1'b0;
            lamp         = 1'b0;
            stage        = PH_IDLE;
            expected_drive.delete();
            readings_owed    <= 0;
            sequence_running <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_STEP_NORMAL:  regs.step_normal        = cfg.data;
                    REG_STEP_REVERSE: regs.step_reverse_brake = cfg.data;
                    REG_HALF_STEP:    regs.half_step_ticks    = cfg.data;
                    REG_DWELL:        regs.dwell_ticks        = cfg.data;
                    REG_MAX_SPEED:    regs.max_speed          = cfg.data;
                    default: ;
                endcase
            end

            if (res.valid && res.ready)
            begin
                if (expected_drive.size() == 0)
                begin
                    misses++;
                    $display("%0t: result beat with none expected, actual level %0d status %0d",
                             $time, res.pwm_level, res.status);
                end
                else
                begin
                    want = expected_drive.pop_front();
                    compare_field("pwm_level", want.pwm_level, res.pwm_level);
                    compare_field("drive_forward", want.drive_forward, res.drive_forward);
                    compare_field("drive_reverse", want.drive_reverse, res.drive_reverse);
                    compare_field("led", want.led, res.led);
                    compare_field("busy_res", want.busy_res, res.busy_res);
                    compare_field("status", want.status, res.status);
                end
            end

            if (cmd.valid && cmd.ready)
            begin
                st = ST_OK;
                if (cmd.kind == KIND_TICK)
                    apply_tick();
                else
                    st = apply_command(cmd.direction_code, cmd.speed_valid, cmd.speed);
                want.pwm_level     = duty;
                want.drive_forward = !swapped;
                want.drive_reverse = swapped;
                want.led           = lamp;
                want.busy_res      = (stage != PH_IDLE);
                want.status        = st;
                expected_drive.push_back(want);
            end

            readings_owed    <= expected_drive.size();
            sequence_running <= (stage != PH_IDLE);
        end
    end

endmodule

@@ verif/tb_motor_reversal_ramp_sequencer.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict for the reversal ramp sequencer. Every beat on cmd
// (tick or command) yields one result beat on res; the checker beside the
// block predicts each one and counts mismatches. Stimulus runs a directed
// pass on the reset settings, then random phases under several register
// settings, and closes with the largest steps and speed limit.
module tb_motor_reversal_ramp_sequencer;
    import mrrs_pkg::*;

    localparam int          IDLE_PCT        = 26;
    localparam int          ITEMS_PER_PHASE = 60;
    // code three is not a direction; the block must treat it as none
    localparam logic [1:0]  DIR_UNUSED      = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               steady;     // both sides run without gaps while set
    logic [SPEED_W-1:0] cur_max;    // max_speed as last programmed
    int                 mismatches;
    int                 owed;
    logic               seq_busy;

    mrrs_in_if  cmd ();
    mrrs_out_if res ();
    mrrs_cfg_if cfg ();

    motor_reversal_ramp_sequencer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res),
        .cfg   (cfg)
    );

    mrrs_ramp_checker ramp_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .res              (res),
        .cfg              (cfg),
        .drive_mismatches (mismatches),
        .readings_owed    (owed),
        .sequence_running (seq_busy)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // result side: stalls about a quarter of the time unless steady
    always @(posedge clk)
        res.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    function automatic item_t make_cmd(input logic [1:0] dir, input logic spd_valid,
                                       input logic [SPEED_W-1:0] spd);
        item_t it;
        it.kind           = KIND_CMD;
        it.direction_code = dir;
        it.speed_valid    = spd_valid;
        it.speed          = spd;
        return it;
    endfunction

    // tick with junk in the unused fields
    function automatic item_t make_tick();
        item_t it;
        it.kind           = KIND_TICK;
        it.direction_code = 2'($urandom_range(0, 3));
        it.speed_valid    = 1'($urandom_range(0, 1));
        it.speed          = 16'($urandom);
        return it;
    endfunction

    function automatic logic [1:0] pick_direction();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return DIR_NONE;
        if (r < 62)
            return DIR_FWD;
        if (r < 94)
            return DIR_REV;
        return DIR_UNUSED;
    endfunction

    // mostly in range, with the limit, one past it and the field max mixed in
    function automatic logic [SPEED_W-1:0] pick_speed();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return cur_max;
            2: return (cur_max == 16'hFFFF) ? cur_max : cur_max + 16'd1;
            3: return 16'hFFFF;
            default: return 16'($urandom_range(0, cur_max));
        endcase
    endfunction

    // Present one beat and return at the edge that accepts it. valid is left
    // high so back-to-back beats never lower and raise it in one step; it is
    // only dropped for a random gap or by the caller when the burst ends.
    task automatic push_beat(input item_t it);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid          <= 1'b1;
        cmd.kind           <= it.kind;
        cmd.direction_code <= it.direction_code;
        cmd.speed_valid    <= it.speed_valid;
        cmd.speed          <= it.speed;
        do
            @(posedge clk);
        while (!cmd.ready);
    endtask

    // Tick until the sequence is over, then wait for every result beat.
    // seq_busy read at an accept edge covers beats up to the one before,
    // so at least one tick always goes first.
    task automatic finish_sequence();
        do
            push_beat(make_tick());
        while (seq_busy);
        cmd.valid <= 1'b0;
        do
            @(posedge clk);
        while (owed != 0);
    endtask

    // bring the level back to zero so the next settings start from rest
    task automatic park();
        finish_sequence();
        push_beat(make_cmd(DIR_NONE, 1'b1, '0));
        finish_sequence();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
    endtask

    // only called with the block idle and no result beat outstanding
    task automatic load_settings(input logic [15:0] step_n, input logic [15:0] brake,
                                 input logic [15:0] half, input logic [15:0] dwell,
                                 input logic [15:0] top_speed);
        write_reg(REG_STEP_NORMAL, step_n);
        write_reg(REG_STEP_REVERSE, brake);
        write_reg(REG_HALF_STEP, half);
        write_reg(REG_DWELL, dwell);
        write_reg(REG_MAX_SPEED, top_speed);
        cfg.valid <= 1'b0;
        cur_max = top_speed;
    endtask

    // Commands dominate while idle, ticks while a sequence runs, so most
    // commands start real ramps and the rest probe the busy refusal.
    // Ticks on an idle block do nothing and are not counted.
    task automatic random_phase(input int quota);
        int  counted;
        bit  is_cmd;
        counted = 0;
        while (counted < quota)
        begin
            if (seq_busy)
                is_cmd = ($urandom_range(0, 99) < 12);
            else
                is_cmd = ($urandom_range(0, 99) < 75);
            if (is_cmd || seq_busy)
                counted++;
            if (is_cmd)
                push_beat(make_cmd(pick_direction(), 1'($urandom_range(0, 99) < 70),
                                   pick_speed()));
            else
                push_beat(make_tick());
        end
    endtask

    initial
    begin
        cmd.valid          = 1'b0;
        cmd.kind           = KIND_TICK;
        cmd.direction_code = DIR_NONE;
        cmd.speed_valid    = 1'b0;
        cmd.speed          = '0;
        cfg.valid          = 1'b0;
        cfg.index          = REG_STEP_NORMAL;
        cfg.data           = '0;
        res.ready          = 1'b0;
        steady             = 1'b0;
        cur_max            = RST_MAX_SPEED;
        rst_n              = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed pass on reset settings: step 200, brake 500, half 25,
        // dwell 200, max 65000; speeds kept small so ramps stay short
        push_beat(make_tick());                              // tick on idle block
        push_beat(make_cmd(DIR_NONE, 1'b0, '0));             // empty command
        push_beat(make_cmd(DIR_FWD, 1'b0, '0));              // already forward
        push_beat(make_cmd(DIR_NONE, 1'b1, 16'd65001));      // one above max_speed
        push_beat(make_cmd(DIR_NONE, 1'b1, 16'hFFFF));       // field max, rejected
        push_beat(make_cmd(DIR_NONE, 1'b1, 16'd400));        // two-step ramp up
        push_beat(make_cmd(DIR_REV, 1'b1, 16'd100));         // refused, busy
        finish_sequence();
        push_beat(make_cmd(DIR_REV, 1'b1, 16'hFFFF));        // bad speed, reversal still runs
        finish_sequence();
        push_beat(make_cmd(DIR_REV, 1'b0, '0));              // already reverse
        // forward plus stop: brake, swap, dwell, back up to 400, then down to 0
        push_beat(make_cmd(DIR_FWD, 1'b1, '0));
        finish_sequence();
        push_beat(make_cmd(DIR_UNUSED, 1'b1, 16'd200));      // code three, speed only
        finish_sequence();
        push_beat(make_cmd(DIR_NONE, 1'b1, '0));
        finish_sequence();
        // at level zero: swap at once, dwell, no steps back so LED stays lit
        push_beat(make_cmd(DIR_REV, 1'b0, '0));
        finish_sequence();

        // largest steps and shortest timing: every ramp is a single step
        load_settings(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'hFFFF);
        random_phase(ITEMS_PER_PHASE);
        park();

        // zero registers act as one; small max keeps unit-step ramps short
        load_settings('0, '0, '0, '0, 16'd40);
        random_phase(ITEMS_PER_PHASE);
        park();

        // gap-free stretch on both sides
        steady <= 1'b1;
        load_settings(16'd1000, 16'd3000, 16'd2, 16'd3, 16'd20000);
        random_phase(ITEMS_PER_PHASE);
        park();
        steady <= 1'b0;

        load_settings(16'($urandom_range(2000, 20000)), 16'($urandom_range(1000, 65535)),
                      16'($urandom_range(1, 3)), 16'($urandom_range(1, 5)),
                      16'($urandom_range(1, 65535)));
        random_phase(ITEMS_PER_PHASE);
        park();

        // max_speed zero: only a zero speed gets through
        load_settings(16'd7, 16'd13, 16'd1, 16'd2, '0);
        random_phase(ITEMS_PER_PHASE);
        park();

        // largest steps and speed limit with brief timing, run without gaps
        steady <= 1'b1;
        load_settings(16'hFFFF, 16'hFFFF, 16'd20, 16'd60, 16'hFFFF);
        push_beat(make_cmd(DIR_FWD, 1'b0, '0));              // swap back if reversed
        finish_sequence();
        push_beat(make_cmd(DIR_NONE, 1'b1, 16'hFFFF));       // one step to the field max
        finish_sequence();

        // idle edges after the last result catch any stray beats
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
design/mrrs_pkg.sv
design/mrrs_in_if.sv
design/mrrs_out_if.sv
design/mrrs_cfg_if.sv
design/mrrs_cfg_regs.sv
design/mrrs_core.sv
design/mrrs_skid.sv
design/motor_reversal_ramp_sequencer.sv
verif/mrrs_ramp_checker.sv
verif/tb_motor_reversal_ramp_sequencer.sv
